>>> rtl/core/rdc_pkg.sv
// shared types, constants and helpers for the radix digit converter
package rdc_pkg;

   // symbol table layout
   localparam int SYM_W        = 7;
   localparam int SYMS_PER_REG = 9;
   localparam int NUM_SYM_REGS = 7;
   localparam int NUM_SYMS     = SYMS_PER_REG * NUM_SYM_REGS;
   localparam int CSR_DATA_W   = SYM_W * SYMS_PER_REG;
   localparam int SYM_FLAT_W   = CSR_DATA_W * NUM_SYM_REGS;
   localparam int SIZE_W       = 6;
   localparam int VALUE_W      = 64;
   localparam int CSR_IDX_W    = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX_SIZE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_0_8 = 3'd1;

   // ascii bounds for letters and digits
   localparam logic [SYM_W-1:0] CHAR_0       = 7'h30;
   localparam logic [SYM_W-1:0] CHAR_9       = 7'h39;
   localparam logic [SYM_W-1:0] CHAR_LOWER_A = 7'h61;
   localparam logic [SYM_W-1:0] CHAR_LOWER_Z = 7'h7a;
   localparam logic [SYM_W-1:0] CHAR_UPPER_A = 7'h41;
   localparam logic [SYM_W-1:0] CHAR_UPPER_Z = 7'h5a;

   // one classified request passed from front to back
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               bad;
   } job_type;

   function automatic logic is_alnum(input logic [SYM_W-1:0] c);
      return (c >= CHAR_0 && c <= CHAR_9) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z);
   endfunction

   function automatic logic [SYM_W-1:0] sym_at(input logic [SYM_FLAT_W-1:0] flat,
                                                input logic [SIZE_W-1:0] idx);
      logic [SYM_W-1:0] c;
      c = '0;
      if (int'(idx) < NUM_SYMS) c = flat[SYM_W*idx +: SYM_W];
      return c;
   endfunction

endpackage

>>> rtl/core/radix_digit_converter_unit.sv
// top level of the radix digit converter: registers, front, queue and back
//
//   channel   ports                                       handshake
//   request   start, busy, req_number_in                  start && !busy
//   result    rsp_strobe, rsp_digit_char,                 strobe, one cycle,
//             rsp_final_digit, rsp_alphabet_bad           no back-pressure
//   config    csr_write_en, csr_index, csr_wdata          write_en, no wait
//
// The front checks the alphabet one symbol per cycle and hands the request to a
// two-entry queue. The back divides by the radix one quotient bit per cycle,
// writing each digit to the digit buffer, then emits the digits from the buffer.
// Reset clears the registers and both sequencers; the buffer needs no clearing.
// Results cannot be stalled; busy holds off requests while the front is working.
module radix_digit_converter_unit import rdc_pkg::*; #(
   parameter int MAX_DIGITS  = 64,
   parameter int MAX_SYMBOLS = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_W-1:0]    req_number_in,
   output logic                  rsp_strobe,
   output logic [SYM_W-1:0]      rsp_digit_char,
   output logic                  rsp_final_digit,
   output logic                  rsp_alphabet_bad,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [SIZE_W-1:0]     radix_size_ff;
   logic [CSR_DATA_W-1:0] sym_reg_ff [NUM_SYM_REGS];
   logic [SYM_FLAT_W-1:0] sym_flat;
   logic [CSR_IDX_W-1:0]  sym_sel;

   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   job_type push_job;
   job_type pop_job;

   assign sym_sel = csr_index - CSR_SYMBOLS_0_8;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_size_ff <= '0;
         for (int i = 0; i < NUM_SYM_REGS; i++) sym_reg_ff[i] <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_RADIX_SIZE: radix_size_ff <= csr_wdata[SIZE_W-1:0];
            default:        sym_reg_ff[sym_sel] <= csr_wdata;
         endcase
      end
   end

   // flat symbol table, symbol 0 in the low bits
   always_comb begin
      for (int i = 0; i < NUM_SYM_REGS; i++) sym_flat[CSR_DATA_W*i +: CSR_DATA_W] = sym_reg_ff[i];
   end

   rdc_front #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .number_in  (req_number_in),
      .radix_size (radix_size_ff),
      .sym_flat   (sym_flat),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   rdc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   rdc_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .radix_size (radix_size_ff),
      .sym_flat   (sym_flat),
      .q_empty    (q_empty),
      .q_job      (pop_job),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_strobe),
      .rsp_char   (rsp_digit_char),
      .rsp_final  (rsp_final_digit),
      .rsp_bad    (rsp_alphabet_bad)
   );

endmodule

>>> rtl/core/rdc_front.sv
// front end: accepts requests and checks the alphabet one symbol per cycle
module rdc_front import rdc_pkg::*; #(
   parameter int MAX_SYMBOLS = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_W-1:0]    number_in,
   input  logic [SIZE_W-1:0]     radix_size,
   input  logic [SYM_FLAT_W-1:0] sym_flat,
   input  logic                  q_full,
   output logic                  q_push,
   output job_type               q_job
);

   typedef enum logic [1:0] {F_IDLE, F_CHECK, F_PUSH} fstate_type;

   fstate_type         state_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [SIZE_W-1:0]  idx_ff;
   logic               bad_ff;

   logic [SYM_W-1:0]   sym_a;
   logic               dup;
   logic               size_bad;

   // symbol under test against every later symbol in the alphabet
   always_comb begin
      sym_a = sym_at(sym_flat, idx_ff);
      dup   = 1'b0;
      for (int b = 0; b < NUM_SYMS; b++) begin
         if (SIZE_W'(b) > idx_ff && SIZE_W'(b) < radix_size &&
             sym_flat[SYM_W*b +: SYM_W] == sym_a) dup = 1'b1;
      end
   end

   assign size_bad = (radix_size < SIZE_W'(2)) ||
                     ({1'b0, radix_size} > (SIZE_W+1)'(MAX_SYMBOLS));
   assign busy     = (state_ff != F_IDLE);
   assign q_push   = (state_ff == F_PUSH) && !q_full;
   assign q_job    = '{value: value_ff, bad: bad_ff};

   // check sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         idx_ff   <= '0;
         bad_ff   <= 1'b0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (start) begin
                  value_ff <= number_in;
                  idx_ff   <= '0;
                  bad_ff   <= size_bad;
                  state_ff <= size_bad ? F_PUSH : F_CHECK;
               end
            end
            F_CHECK: begin
               if (!is_alnum(sym_a) || dup) begin
                  bad_ff   <= 1'b1;
                  state_ff <= F_PUSH;
               end else if (idx_ff == radix_size - SIZE_W'(1)) begin
                  state_ff <= F_PUSH;
               end else begin
                  idx_ff <= idx_ff + SIZE_W'(1);
               end
            end
            F_PUSH: begin
               if (!q_full) state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

>>> rtl/core/rdc_fifo.sv
// two-entry queue of classified requests between front and back
module rdc_fifo import rdc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type pop_job,
   output logic    full,
   output logic    empty
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_job = entry_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

>>> rtl/core/rdc_back.sv
// back end: bit-serial division into a digit buffer, then emission msd first
module rdc_back import rdc_pkg::*; #(
   parameter int MAX_DIGITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [SIZE_W-1:0]     radix_size,
   input  logic [SYM_FLAT_W-1:0] sym_flat,
   input  logic                  q_empty,
   input  job_type               q_job,
   output logic                  q_pop,
   output logic                  rsp_valid,
   output logic [SYM_W-1:0]      rsp_char,
   output logic                  rsp_final,
   output logic                  rsp_bad
);

   localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CW = $clog2(MAX_DIGITS + 1);

   typedef enum logic [1:0] {B_IDLE, B_DIV, B_RD, B_OUT} bstate_type;

   bstate_type         state_ff;
   logic [VALUE_W-1:0] val_ff;
   logic [SIZE_W-1:0]  rem_ff;
   logic [5:0]         bit_cnt_ff;
   logic [CW-1:0]      total_ff;
   logic [AW-1:0]      ptr_ff;
   logic               rsp_valid_ff;
   logic [SYM_W-1:0]   rsp_char_ff;
   logic               rsp_final_ff;
   logic               rsp_bad_ff;

   logic [SIZE_W-1:0]  digit_mem [MAX_DIGITS];
   logic [SIZE_W-1:0]  rd_data_ff;

   logic [SIZE_W:0]    rem_sh;
   logic [SIZE_W:0]    rem_diff;
   logic               ge;
   logic [SIZE_W-1:0]  rem_in;
   logic [VALUE_W-1:0] val_in;
   logic               last_bit;
   logic               mem_we;
   logic [CW-1:0]      total_in;

   // one restoring-division step per cycle
   always_comb begin
      rem_sh   = {rem_ff, val_ff[VALUE_W-1]};
      rem_diff = rem_sh - {1'b0, radix_size};
      ge       = (rem_sh >= {1'b0, radix_size});
      rem_in   = ge ? rem_diff[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
      val_in   = {val_ff[VALUE_W-2:0], ge};
      last_bit = (bit_cnt_ff == 6'd63);
      mem_we   = (state_ff == B_DIV) && last_bit && (int'(total_ff) < MAX_DIGITS);
      total_in = mem_we ? total_ff + CW'(1) : total_ff;
   end

   assign q_pop = (state_ff == B_IDLE) && !q_empty;

   // digit buffer, registered read
   always_ff @(posedge clock) begin
      if (mem_we) digit_mem[total_ff[AW-1:0]] <= rem_in;
      rd_data_ff <= digit_mem[ptr_ff];
   end

   // divide and emit sequencer with registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         bit_cnt_ff   <= '0;
         total_ff     <= '0;
         ptr_ff       <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  if (q_job.bad) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_char_ff  <= '0;
                     rsp_final_ff <= 1'b1;
                     rsp_bad_ff   <= 1'b1;
                  end else begin
                     val_ff     <= q_job.value;
                     rem_ff     <= '0;
                     bit_cnt_ff <= '0;
                     total_ff   <= '0;
                     state_ff   <= B_DIV;
                  end
               end
            end
            B_DIV: begin
               val_ff     <= val_in;
               rem_ff     <= last_bit ? '0 : rem_in;
               bit_cnt_ff <= bit_cnt_ff + 6'd1;
               if (last_bit) begin
                  total_ff <= total_in;
                  if (val_in == '0) begin
                     ptr_ff   <= AW'(total_in - CW'(1));
                     state_ff <= B_RD;
                  end
               end
            end
            B_RD: state_ff <= B_OUT;
            B_OUT: begin
               rsp_valid_ff <= 1'b1;
               rsp_char_ff  <= sym_at(sym_flat, rd_data_ff);
               rsp_final_ff <= (ptr_ff == '0);
               rsp_bad_ff   <= 1'b0;
               if (ptr_ff == '0) begin
                  state_ff <= B_IDLE;
               end else begin
                  ptr_ff   <= ptr_ff - AW'(1);
                  state_ff <= B_RD;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_char  = rsp_char_ff;
   assign rsp_final = rsp_final_ff;
   assign rsp_bad   = rsp_bad_ff;

endmodule
